// File: rtl/core/msr_pkg.sv
// msr_pkg: shared constants and types for the masked run segmenter
// used by msr_step, msr_emit and masked_run_segmenter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

	localparam int POS_W       = 32;
	localparam int OUT_W       = 32;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int SHORT_LIMIT = 20;
	localparam int MERGE_GAP   = 9;
	localparam int BUF_DEPTH   = 10;
	localparam int CNT_W       = 4;
	localparam int FIELD_W     = 5;
	localparam int ENTRY_W     = 2 * FIELD_W;
	localparam int STREAK_W    = 4;
	localparam int CMP_W       = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;

	localparam logic [CFG_W-1:0]     SEG_RESET   = CFG_W'(1000000);
	localparam logic [CHAR_W-1:0]    MASK_UPPER  = 8'h4E;
	localparam logic [CHAR_W-1:0]    MASK_LOWER  = 8'h6E;
	localparam logic [STREAK_W-1:0]  STREAK_MAX  = {STREAK_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_SEG_LENGTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_ENABLE = 1'b1;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] nb;
		logic [OUT_W-1:0] e0_start;
		logic [OUT_W-1:0] e0_end;
		logic [OUT_W-1:0] e1_start;
		logic [OUT_W-1:0] e1_end;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/core/msr_step.sv
// msr_step: input register, configuration, sequence state and per-byte step logic
// depends on msr_pkg; hands a result descriptor to msr_emit
`timescale 1ns / 1ps
`default_nettype none

module msr_step
	import msr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [CHAR_W-1:0]    base_char,
	input  wire logic                 last_base,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 done,
	output logic                      res_load,
	output res_t                      res,
	input  wire logic [CNT_W-1:0]     rd_idx,
	output entry_t                    rd_entry
);

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                last_s1;

	logic [CFG_W-1:0]    seg_q;
	logic                merge_q;

	logic [POS_W-1:0]    pos_q, pos_n;
	logic                open_q, open_n;
	logic [POS_W-1:0]    rb_q, rb_n;
	logic [POS_W-1:0]    rlu_q, rlu_n;
	logic [POS_W-1:0]    npb_q, npb_n;
	logic [STREAK_W-1:0] streak_q, streak_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic [FIELD_W-1:0]  start_q;
	entry_t              sbuf_q [BUF_DEPTH];

	logic                fire;
	logic                unmasked;
	logic                is_short;
	logic                raw_open;
	logic                dump;
	logic                sbuf_we;
	logic                tail_v;
	logic [FIELD_W-1:0]  tail_start;
	logic [STREAK_W-1:0] thr;
	logic [STREAK_W-1:0] streak_inc;
	logic [CMP_W-1:0]    seg_w;
	logic [CMP_W-1:0]    span;
	logic                piece_due;
	logic [POS_W-1:0]    piece_end;
	logic [POS_W-1:0]    piece_next;
	logic                len_cur_ok;
	logic                len_nxt_ok;
	logic                ev1_v, ev2_v;
	logic [POS_W-1:0]    ev1_s, ev1_e, ev2_s, ev2_e;

	assign fire     = valid_s1 && done;
	assign in_stall = valid_s1 && !done;
	assign rd_entry = sbuf_q[rd_idx];

	assign unmasked = !(char_s1 == MASK_UPPER || char_s1 == MASK_LOWER);
	assign is_short = pos_q < POS_W'(SHORT_LIMIT);
	assign raw_open = open_q && (streak_q == '0);
	assign thr      = merge_q ? STREAK_W'(MERGE_GAP) : STREAK_W'(1);
	assign seg_w    = (seg_q < CFG_W'(SHORT_LIMIT)) ? CMP_W'(SHORT_LIMIT) : CMP_W'(seg_q);
	assign span     = CMP_W'(pos_q - npb_q) + CMP_W'(1);
	assign piece_due  = span >= (seg_w << 1);
	assign piece_end  = POS_W'(CMP_W'(npb_q) + seg_w - CMP_W'(1));
	assign piece_next = POS_W'(CMP_W'(npb_q) + seg_w);
	assign streak_inc = (streak_q == STREAK_MAX) ? STREAK_MAX : streak_q + STREAK_W'(1);
	assign len_cur_ok = !merge_q || ((rlu_q - rb_q) >= POS_W'(SHORT_LIMIT - 1));

	always_comb begin
		pos_n    = pos_q;
		open_n   = open_q;
		rb_n     = rb_q;
		rlu_n    = rlu_q;
		npb_n    = npb_q;
		streak_n = streak_q;
		ev1_v    = 1'b0;
		ev1_s    = npb_q;
		ev1_e    = rlu_q;
		if (unmasked) begin
			if (open_q && streak_q >= thr) begin
				ev1_v  = len_cur_ok;
				open_n = 1'b1;
				rb_n   = pos_q;
				rlu_n  = pos_q;
				npb_n  = pos_q;
			end else if (open_q) begin
				rlu_n = pos_q;
				if (piece_due) begin
					ev1_v = 1'b1;
					ev1_e = piece_end;
					npb_n = piece_next;
				end
			end else begin
				open_n = 1'b1;
				rb_n   = pos_q;
				rlu_n  = pos_q;
				npb_n  = pos_q;
			end
			streak_n = '0;
		end else if (open_q) begin
			if (streak_inc >= thr) begin
				ev1_v    = len_cur_ok;
				open_n   = 1'b0;
				streak_n = '0;
			end else begin
				streak_n = streak_inc;
			end
		end
	end

	assign len_nxt_ok = !merge_q || ((rlu_n - rb_n) >= POS_W'(SHORT_LIMIT - 1));
	assign dump       = last_s1 && merge_q && is_short;
	assign ev2_v      = last_s1 && !dump && open_n && len_nxt_ok;
	assign ev2_s      = npb_n;
	assign ev2_e      = rlu_n;

	assign sbuf_we    = !unmasked && is_short && raw_open && (cnt_q < CNT_W'(BUF_DEPTH));
	assign cnt_n      = cnt_q + CNT_W'(sbuf_we);
	assign tail_v     = unmasked && (cnt_n < CNT_W'(BUF_DEPTH));
	assign tail_start = raw_open ? start_q : pos_q[FIELD_W-1:0];

	always_comb begin
		res          = '0;
		res.e0_start = OUT_W'(ev1_s);
		res.e0_end   = OUT_W'(ev1_e);
		res.e1_start = OUT_W'(ev2_s);
		res.e1_end   = OUT_W'(ev2_e);
		if (dump) begin
			res.nb       = cnt_n;
			res.total    = cnt_n + CNT_W'(tail_v);
			res.e0_start = OUT_W'(tail_start);
			res.e0_end   = OUT_W'(pos_q);
		end else begin
			res.total = CNT_W'(ev1_v) + CNT_W'(ev2_v);
			if (!ev1_v) begin
				res.e0_start = OUT_W'(ev2_s);
				res.e0_end   = OUT_W'(ev2_e);
			end
		end
	end

	assign res_load = fire && (res.total != '0);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= base_char;
			last_s1 <= last_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_RESET;
			merge_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SEG_LENGTH:   seg_q   <= cfg_data;
				REG_MERGE_ENABLE: merge_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			open_q   <= 1'b0;
			rb_q     <= '0;
			rlu_q    <= '0;
			npb_q    <= '0;
			streak_q <= '0;
			cnt_q    <= '0;
		end else if (fire) begin
			if (last_s1) begin
				pos_q    <= '0;
				open_q   <= 1'b0;
				rb_q     <= '0;
				rlu_q    <= '0;
				npb_q    <= '0;
				streak_q <= '0;
				cnt_q    <= '0;
			end else begin
				pos_q    <= (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + POS_W'(1);
				open_q   <= open_n;
				rb_q     <= rb_n;
				rlu_q    <= rlu_n;
				npb_q    <= npb_n;
				streak_q <= streak_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && unmasked && !raw_open) begin
			start_q <= pos_q[FIELD_W-1:0];
		end
		if (fire && sbuf_we) begin
			sbuf_q[cnt_q] <= {FIELD_W'(pos_q - POS_W'(1)), start_q};
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/msr_emit.sv
// msr_emit: result register, sends the results of one byte one transfer per cycle while out_stall is low
// depends on msr_pkg; reads buffered short runs from msr_step
`timescale 1ns / 1ps
`default_nettype none

module msr_emit
	import msr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_load,
	input  wire res_t             res,
	output logic                  done,
	output logic [CNT_W-1:0]      rd_idx,
	input  wire entry_t           rd_entry,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [OUT_W-1:0]      piece_start,
	output logic [OUT_W-1:0]      piece_end,
	output logic                  last_of_run
);

	logic             valid_q;
	logic [CNT_W-1:0] idx_q;
	res_t             res_q;
	logic             last_item;
	logic             xfer;

	assign last_item   = idx_q == (res_q.total - CNT_W'(1));
	assign xfer        = valid_q && !out_stall;
	assign done        = !valid_q || (xfer && last_item);
	assign out_valid   = valid_q;
	assign last_of_run = last_item;
	assign rd_idx      = idx_q;

	always_comb begin
		if (idx_q < res_q.nb) begin
			piece_start = OUT_W'(rd_entry[FIELD_W-1:0]);
			piece_end   = OUT_W'(rd_entry[ENTRY_W-1:FIELD_W]);
		end else if (idx_q == res_q.nb) begin
			piece_start = res_q.e0_start;
			piece_end   = res_q.e0_end;
		end else begin
			piece_start = res_q.e1_start;
			piece_end   = res_q.e1_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (res_load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (xfer) begin
			if (last_item) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/masked_run_segmenter.sv
// path: a byte passes the input register, then the result register, before its
//   first result is offered
// throughput: one byte per cycle while each byte gives at most one result and out_stall
//   is low; a byte with n results holds the input until its last result is taken, one
//   result per cycle leaves the single result register while out_stall is low
// reset: asynchronous, active low; seg_length 1000000, merge_enable 1,
//   sequence state zero, short run buffer contents not reset
`timescale 1ns / 1ps
`default_nettype none

module masked_run_segmenter
	import msr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [CHAR_W-1:0]    base_char,
	input  wire logic                 last_base,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [OUT_W-1:0]          piece_start,
	output logic [OUT_W-1:0]          piece_end,
	output logic                      last_of_run
);

	logic             done;
	logic             res_load;
	res_t             res;
	logic [CNT_W-1:0] rd_idx;
	entry_t           rd_entry;

	msr_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.base_char (base_char),
		.last_base (last_base),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.res_load  (res_load),
		.res       (res),
		.rd_idx    (rd_idx),
		.rd_entry  (rd_entry)
	);

	msr_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_load    (res_load),
		.res         (res),
		.done        (done),
		.rd_idx      (rd_idx),
		.rd_entry    (rd_entry),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.piece_start (piece_start),
		.piece_end   (piece_end),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// File: bench/masked_run_segmenter_tb.sv
// masked_run_segmenter_tb: self-checking bench for the masked run segmenter
// keeps its own copy of the run state, predicts every piece and checks each output transfer in order
// depends on msr_pkg and masked_run_segmenter
`timescale 1ns / 1ps

module masked_run_segmenter_tb
	import msr_pkg::*;
();

	typedef struct packed {
		logic [OUT_W-1:0] pstart;
		logic [OUT_W-1:0] pend;
		logic             plast;
	} piece_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CHAR_W-1:0]    base_char;
	logic                 last_base;
	logic                 out_valid;
	logic                 out_stall;
	logic [OUT_W-1:0]     piece_start;
	logic [OUT_W-1:0]     piece_end;
	logic                 last_of_run;

	// register copies
	logic [CFG_W-1:0] seg_cfg = SEG_RESET;
	logic             merge_cfg = 1'b1;

	// run state copy
	logic [63:0]        seq_pos = '0;
	logic               run_live = 1'b0;
	logic [63:0]        run_first = '0;
	logic [63:0]        run_lastu = '0;
	logic [63:0]        piece_from = '0;
	logic [STREAK_W-1:0] gap_count = '0;
	logic [ENTRY_W-1:0] short_runs [BUF_DEPTH];
	logic [CNT_W-1:0]   short_cnt = '0;

	piece_t      step_list[$];
	piece_t      pieces_due[$];
	logic [7:0]  seq_bytes[$];
	int          mismatches = 0;
	int          hold_left = 0;
	int          burst_left = 0;
	logic        idle_on = 1'b0;

	masked_run_segmenter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.base_char  (base_char),
		.last_base  (last_base),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.piece_start(piece_start),
		.piece_end  (piece_end),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	function automatic void add_byte(input logic [7:0] b);
		seq_bytes = {seq_bytes, b};
	endfunction

	function automatic void add_piece(input logic [63:0] s, input logic [63:0] e);
		piece_t pc;
		if (step_list.size() < BUF_DEPTH) begin
			pc.pstart = s[OUT_W-1:0];
			pc.pend = e[OUT_W-1:0];
			pc.plast = 1'b0;
			step_list = {step_list, pc};
		end
	endfunction

	function automatic void end_run(input logic [63:0] min_len);
		if (run_lastu - run_first + 64'd1 >= min_len) begin
			add_piece(piece_from, run_lastu);
		end
		run_live = 1'b0;
		gap_count = '0;
	endfunction

	function automatic void predict_pieces(input logic [7:0] ch, input logic lst);
		logic                unm;
		logic                merge;
		logic                is_short;
		logic                raw_open;
		logic [STREAK_W-1:0] thr;
		logic [63:0]         min_len;
		logic [63:0]         seg;
		logic [63:0]         p;
		logic [63:0]         pm1;
		piece_t              done;
		int                  i;
		unm = !(ch == MASK_UPPER || ch == MASK_LOWER);
		merge = merge_cfg;
		thr = merge ? STREAK_W'(MERGE_GAP) : STREAK_W'(1);
		min_len = merge ? 64'(SHORT_LIMIT) : 64'd1;
		seg = (64'(seg_cfg) < 64'(SHORT_LIMIT)) ? 64'(SHORT_LIMIT) : 64'(seg_cfg);
		p = seq_pos;
		pm1 = p - 64'd1;
		is_short = p < 64'(SHORT_LIMIT);
		raw_open = run_live && gap_count == '0;
		step_list.delete();
		if (unm) begin
			if (is_short && !raw_open && short_cnt < BUF_DEPTH) begin
				short_runs[short_cnt] = {{FIELD_W{1'b0}}, p[FIELD_W-1:0]};
			end
			if (run_live && gap_count >= thr) begin
				end_run(min_len);
			end
			if (run_live) begin
				run_lastu = p;
				gap_count = '0;
				if (p - piece_from + 64'd1 >= 64'd2 * seg) begin
					add_piece(piece_from, piece_from + seg - 64'd1);
					piece_from = piece_from + seg;
				end
			end else begin
				run_live = 1'b1;
				run_first = p;
				run_lastu = p;
				piece_from = p;
				gap_count = '0;
			end
		end else begin
			if (is_short && raw_open && short_cnt < BUF_DEPTH) begin
				short_runs[short_cnt][ENTRY_W-1:FIELD_W] = pm1[FIELD_W-1:0];
				short_cnt++;
			end
			if (run_live) begin
				if (gap_count < STREAK_MAX) begin
					gap_count++;
				end
				if (gap_count >= thr) begin
					end_run(min_len);
				end
			end
		end
		if (lst) begin
			if (merge && is_short) begin
				step_list.delete();
				for (i = 0; i < short_cnt && i < BUF_DEPTH; i++) begin
					add_piece(64'(short_runs[i][FIELD_W-1:0]),
						64'(short_runs[i][ENTRY_W-1:FIELD_W]));
				end
				if (unm && short_cnt < BUF_DEPTH) begin
					add_piece(64'(short_runs[short_cnt][FIELD_W-1:0]), p);
				end
			end else if (run_live) begin
				end_run(min_len);
			end
			seq_pos = '0;
			run_live = 1'b0;
			run_first = '0;
			run_lastu = '0;
			piece_from = '0;
			gap_count = '0;
			short_cnt = '0;
		end else begin
			seq_pos = (p < 64'hFFFF_FFFF) ? p + 64'd1 : p;
		end
		foreach (step_list[j]) begin
			done = step_list[j];
			done.plast = (j == step_list.size() - 1);
			pieces_due = {pieces_due, done};
		end
	endfunction

	always @(posedge clk) begin : monitor
		piece_t want;
		if (in_valid && !in_stall) begin
			predict_pieces(base_char, last_base);
		end
		if (out_valid && !out_stall) begin
			if (pieces_due.size() == 0) begin
				report_mismatch("piece with none expected", piece_start, piece_end);
			end else begin
				want = pieces_due.pop_front();
				if (piece_start !== want.pstart) begin
					report_mismatch("piece_start", piece_start, want.pstart);
				end
				if (piece_end !== want.pend) begin
					report_mismatch("piece_end", piece_end, want.pend);
				end
				if (last_of_run !== want.plast) begin
					report_mismatch("last_of_run", last_of_run, want.plast);
				end
			end
		end
	end

	// receiver: a long hold when a test sets hold_left, else random stall bursts while idle_on
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(0, 6);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_base(input logic [7:0] ch, input logic lst);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		base_char <= ch;
		last_base <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_bytes(input int from, input int upto);
		int i;
		for (i = from; i < upto; i++) begin
			send_base(seq_bytes[i], i == seq_bytes.size() - 1);
		end
	endtask

	task automatic send_sequence();
		send_bytes(0, seq_bytes.size());
	endtask

	// sender pause until every expected piece has arrived
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pieces_due.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		if (idx == REG_SEG_LENGTH) begin
			seg_cfg = val;
		end else begin
			merge_cfg = val[0];
		end
	endtask

	function automatic logic [7:0] pick_unmasked();
		logic [7:0] b;
		case ($urandom_range(0, 4))
			0: b = "A";
			1: b = "C";
			2: b = "G";
			3: b = "T";
			default: b = 8'($urandom_range(0, 255));
		endcase
		if (b == MASK_UPPER || b == MASK_LOWER) begin
			b = "a";
		end
		return b;
	endfunction

	function automatic logic [7:0] pick_masked();
		return $urandom_range(0, 1) ? MASK_UPPER : MASK_LOWER;
	endfunction

	function automatic void build_noise(input int len, input int mask_pct);
		seq_bytes.delete();
		repeat (len) begin
			add_byte(($urandom_range(0, 99) < mask_pct) ? pick_masked() : pick_unmasked());
		end
	endfunction

	function automatic void build_runs(input int nruns, input int run_max, input int gap_max);
		int k;
		seq_bytes.delete();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, gap_max)) add_byte(pick_masked());
		end
		for (k = 0; k < nruns; k++) begin
			repeat ($urandom_range(1, run_max)) add_byte(pick_unmasked());
			if (k < nruns - 1 || $urandom_range(0, 1)) begin
				repeat ($urandom_range(1, gap_max)) add_byte(pick_masked());
			end
		end
	endfunction

	task automatic test_directed_edges();
		int k;
		seq_bytes.delete();
		add_byte(8'h00);
		add_byte(MASK_UPPER);
		add_byte(8'hFF);
		add_byte(MASK_LOWER);
		add_byte("A");
		send_sequence();
		// ten single-base runs in a short sequence, all flushed by the final byte
		seq_bytes.delete();
		for (k = 0; k < SHORT_LIMIT; k++) begin
			if (k % 2 == 0) begin
				add_byte(pick_unmasked());
			end else begin
				add_byte((k % 4 == 1) ? MASK_UPPER : MASK_LOWER);
			end
		end
		send_sequence();
	endtask

	task automatic test_short_sequences();
		int k;
		int len;
		for (k = 0; k < 3; k++) begin
			wait_idle();
			write_reg(REG_MERGE_ENABLE, CFG_W'(k != 2));
			len = (k == 0) ? SHORT_LIMIT : (k == 1) ? SHORT_LIMIT + 1 : $urandom_range(1, 19);
			build_noise(len, 40);
			send_sequence();
		end
	endtask

	task automatic test_merge_gaps();
		wait_idle();
		write_reg(REG_SEG_LENGTH, CFG_W'(SHORT_LIMIT));
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		build_runs(3, 12, 11);
		send_sequence();
	endtask

	task automatic test_raw_runs();
		wait_idle();
		write_reg(REG_MERGE_ENABLE, CFG_W'(0));
		write_reg(REG_SEG_LENGTH, CFG_W'(0));
		build_noise(16, 40);
		send_sequence();
	endtask

	task automatic test_piece_cutting();
		wait_idle();
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		write_reg(REG_SEG_LENGTH, CFG_W'(SHORT_LIMIT - 1));
		seq_bytes.delete();
		repeat ($urandom_range(40, 44)) add_byte(pick_unmasked());
		repeat (MERGE_GAP) add_byte(pick_masked());
		repeat (3) add_byte(pick_unmasked());
		send_sequence();
	endtask

	task automatic test_config_midsequence();
		// seg_length shrinks in the middle of a run
		wait_idle();
		write_reg(REG_SEG_LENGTH, '1);
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		seq_bytes.delete();
		repeat (44) add_byte(pick_unmasked());
		send_bytes(0, 24);
		wait_idle();
		write_reg(REG_SEG_LENGTH, CFG_W'(SHORT_LIMIT));
		send_bytes(24, seq_bytes.size());
		// merge turned off while masked bases trail the open run
		wait_idle();
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		seq_bytes.delete();
		repeat (SHORT_LIMIT) add_byte(pick_unmasked());
		repeat (3) add_byte(pick_masked());
		repeat (4) add_byte(pick_unmasked());
		send_bytes(0, 23);
		wait_idle();
		write_reg(REG_MERGE_ENABLE, CFG_W'(0));
		send_bytes(23, seq_bytes.size());
		// merge turned on inside a short sequence
		build_noise(6, 40);
		send_bytes(0, 5);
		wait_idle();
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		send_bytes(5, 6);
	endtask

	task automatic test_backpressure();
		int k;
		wait_idle();
		write_reg(REG_SEG_LENGTH, CFG_W'(SHORT_LIMIT));
		write_reg(REG_MERGE_ENABLE, CFG_W'(0));
		@(posedge clk);
		hold_left = 80;
		@(negedge clk);
		// raw single-base runs, one piece per masked byte, while the receiver holds off
		seq_bytes.delete();
		for (k = 0; k < SHORT_LIMIT; k++) begin
			add_byte((k % 2 == 0) ? pick_unmasked() : pick_masked());
		end
		send_sequence();
	endtask

	task automatic test_wide_seg_length();
		wait_idle();
		write_reg(REG_SEG_LENGTH, CFG_W'($urandom()));
		write_reg(REG_MERGE_ENABLE, CFG_W'($urandom_range(0, 1)));
		build_noise(24, 30);
		send_sequence();
	endtask

	task automatic test_final_stream();
		wait_idle();
		write_reg(REG_SEG_LENGTH, CFG_W'(SHORT_LIMIT));
		write_reg(REG_MERGE_ENABLE, CFG_W'(1));
		build_runs(2, 20, 10);
		send_sequence();
	endtask

	initial begin
		int w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		base_char = '0;
		last_base = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);
		test_directed_edges();
		idle_on = 1'b1;
		test_short_sequences();
		test_merge_gaps();
		test_raw_runs();
		test_piece_cutting();
		test_config_midsequence();
		test_backpressure();
		test_wide_seg_length();
		idle_on = 1'b0;
		test_final_stream();
		in_valid <= 1'b0;
		for (w = 0; w < 4000 && pieces_due.size() != 0; w++) @(negedge clk);
		repeat (10) @(negedge clk);
		if (pieces_due.size() != 0) begin
			report_mismatch("pieces never delivered", pieces_due.size(), 0);
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
